[src/pwss_pkg.sv]
// package for the priority work stealing scheduler
package pwss_pkg;

    localparam int NUM_WORKERS_DEF    = 4;
    localparam int LIST_DEPTH_DEF     = 16;
    localparam int NUM_PRIORITIES_DEF = 3;

    localparam int TAG_W  = 16;
    localparam int KIND_W = 1;
    localparam int WRK_W  = 3;
    localparam int PRI_W  = 2;
    localparam int SRC_W  = 2;
    localparam int VIC_W  = 2;
    localparam int CFG_W  = 3;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_TAKE = 1'b1;

    localparam logic [SRC_W-1:0] SRC_OWN    = 2'd0;
    localparam logic [SRC_W-1:0] SRC_GLOBAL = 2'd1;
    localparam logic [SRC_W-1:0] SRC_STOLEN = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

[src/pwss_ram.sv]
// generic single port ram with registered read
module pwss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write or registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[src/priority_work_stealing_scheduler.sv]
// top level of the priority work stealing scheduler
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | in_valid in_ready + request fields   | in
//  output  | out_valid out_ready + result fields  | out
//  config  | cfg_valid cfg_ready cfg_data         | in
//
// a push steps through idle/accept, scan with the tag write, then result
// a take probes sets in turn (own when the worker is in use, global, then up to
// workers_in_use victims), and reads the tag when a task is found
// the set scan walks list counts held in flip-flops; tags sit in one ram
// reset clears all list heads and counts at once; tags are undefined until written
// a stalled result holds in the output register while out_ready is low;
// no request is taken meanwhile
module priority_work_stealing_scheduler #(
    parameter int NUM_WORKERS    = pwss_pkg::NUM_WORKERS_DEF,
    parameter int LIST_DEPTH     = pwss_pkg::LIST_DEPTH_DEF,
    parameter int NUM_PRIORITIES = pwss_pkg::NUM_PRIORITIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pwss_pkg::KIND_W-1:0] kind,
    input  logic [pwss_pkg::WRK_W-1:0]  worker,
    input  logic [pwss_pkg::PRI_W-1:0]  priority_req,
    input  logic [pwss_pkg::TAG_W-1:0]  task_tag,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        granted,
    output logic                        dropped,
    output logic [pwss_pkg::TAG_W-1:0]  task_out,
    output logic [pwss_pkg::PRI_W-1:0]  prio_out,
    output logic [pwss_pkg::SRC_W-1:0]  source,
    output logic [pwss_pkg::VIC_W-1:0]  victim,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pwss_pkg::CFG_W-1:0]  cfg_data
);
    import pwss_pkg::*;

    localparam int NUM_SETS  = NUM_WORKERS + 1;
    localparam int NUM_LISTS = NUM_SETS * NUM_PRIORITIES;
    localparam int SET_W     = $clog2(NUM_SETS);
    localparam int LIST_W    = $clog2(NUM_LISTS);
    localparam int POS_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W    = $clog2(NUM_LISTS * LIST_DEPTH);
    localparam int PI_W      = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int WCNT_W    = $clog2(NUM_WORKERS + 1);
    localparam logic [SET_W-1:0] GLOBAL_SET = SET_W'(NUM_WORKERS);

    // list bookkeeping in flip-flops
    logic [POS_W-1:0] head_reg  [NUM_LISTS];
    logic [CNT_W-1:0] count_reg [NUM_LISTS];
    logic [CFG_W-1:0] wiu_reg;

    state_t state_reg, state_next;
    logic             kind_reg;
    logic [SET_W-1:0] req_set_reg;
    logic             local_reg;
    logic [PI_W-1:0]  prio_reg;
    logic [TAG_W-1:0] tag_reg;
    // scan phase: 0 own, 1 global, 2 steal
    logic [1:0]       phase_reg;
    logic [SET_W-1:0] probe_reg;
    logic [WCNT_W-1:0] steps_reg;

    logic             granted_reg, dropped_reg;
    logic [PRI_W-1:0] prio_out_reg;
    logic [SRC_W-1:0] source_reg;
    logic [VIC_W-1:0] victim_reg;

    logic [WCNT_W-1:0] n_act;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [TAG_W-1:0]  ram_rdata;
    logic [TAG_W-1:0]  ram_rdata_hold;

    // effective worker count
    always_comb
    begin
        if (wiu_reg == '0)
            n_act = WCNT_W'(1);
        else if (32'(wiu_reg) > NUM_WORKERS)
            n_act = WCNT_W'(NUM_WORKERS);
        else
            n_act = WCNT_W'(wiu_reg);
    end

    // priority scan of the probed set
    logic             set_hit;
    logic [PI_W-1:0]  set_prio;
    always_comb
    begin
        set_hit  = 1'b0;
        set_prio = '0;
        for (int p = NUM_PRIORITIES - 1; p >= 0; p--)
        begin
            if (count_reg[LIST_W'(32'(probe_reg) * NUM_PRIORITIES + p)] != '0)
            begin
                set_hit  = 1'b1;
                set_prio = PI_W'(p);
            end
        end
    end

    logic [LIST_W-1:0] probe_list;
    assign probe_list = LIST_W'(32'(probe_reg) * NUM_PRIORITIES + 32'(set_prio));

    logic [LIST_W-1:0] push_list;
    assign push_list = LIST_W'(32'(req_set_reg) * NUM_PRIORITIES + 32'(prio_reg));

    logic push_full;
    assign push_full = (32'(count_reg[push_list]) >= LIST_DEPTH);

    // next rotated victim
    logic [SET_W-1:0] probe_inc;
    always_comb
    begin
        if (32'(probe_reg) + 1 >= 32'(n_act))
            probe_inc = '0;
        else
            probe_inc = probe_reg + SET_W'(1);
    end

    // tail and back positions before wrapping
    logic [31:0] push_sum, back_sum;
    assign push_sum = 32'(head_reg[push_list]) + 32'(count_reg[push_list]);
    assign back_sum = 32'(head_reg[probe_list]) + 32'(count_reg[probe_list]) - 32'd1;

    // ram address of the list slot in use
    logic [POS_W-1:0] slot_pos;
    always_comb
    begin
        if (kind_reg == KIND_PUSH)
            slot_pos = (push_sum >= 32'(LIST_DEPTH)) ? POS_W'(push_sum - 32'(LIST_DEPTH))
                                                     : POS_W'(push_sum);
        else if (phase_reg == 2'd2)
            slot_pos = (back_sum >= 32'(LIST_DEPTH)) ? POS_W'(back_sum - 32'(LIST_DEPTH))
                                                     : POS_W'(back_sum);
        else
            slot_pos = head_reg[probe_list];
    end

    logic [LIST_W-1:0] slot_list;
    assign slot_list = (kind_reg == KIND_PUSH) ? push_list : probe_list;
    assign ram_addr  = ADDR_W'(32'(slot_list) * LIST_DEPTH + 32'(slot_pos));
    assign ram_we    = (state_reg == ST_SCAN) && (kind_reg == KIND_PUSH) && !push_full;

    pwss_ram #(.WIDTH(TAG_W), .DEPTH(NUM_LISTS * LIST_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (tag_reg),
        .rdata (ram_rdata)
    );

    logic scan_end;
    assign scan_end = (phase_reg == 2'd2) && (32'(steps_reg) + 1 >= 32'(n_act));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid) state_next = ST_SCAN;
            ST_SCAN:
                if (kind_reg == KIND_PUSH) state_next = ST_DONE;
                else if (set_hit) state_next = ST_READ;
                else if (scan_end) state_next = ST_DONE;
            ST_READ:
                state_next = ST_DONE;
            ST_DONE:
                if (out_ready) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_DONE);
        cfg_ready = (state_reg == ST_IDLE);
    end

    // sequencer and list updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wiu_reg   <= CFG_W'(NUM_WORKERS);
            for (int l = 0; l < NUM_LISTS; l++)
            begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            granted_reg <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                wiu_reg <= cfg_data;
            case (state_reg)
                ST_IDLE:
                    if (in_valid)
                    begin
                        granted_reg <= 1'b0;
                        dropped_reg <= 1'b0;
                        prio_out_reg <= '0;
                        source_reg  <= SRC_OWN;
                        victim_reg  <= '0;
                        steps_reg   <= '0;
                        if (32'(priority_req) >= NUM_PRIORITIES)
                            prio_reg <= PI_W'(NUM_PRIORITIES - 1);
                        else
                            prio_reg <= PI_W'(priority_req);
                        if (32'(worker) < 32'(n_act))
                        begin
                            local_reg   <= 1'b1;
                            req_set_reg <= SET_W'(worker);
                            probe_reg   <= SET_W'(worker);
                            phase_reg   <= 2'd0;
                        end
                        else
                        begin
                            local_reg   <= 1'b0;
                            req_set_reg <= GLOBAL_SET;
                            probe_reg   <= GLOBAL_SET;
                            phase_reg   <= 2'd1;
                        end
                    end
                ST_SCAN:
                    if (kind_reg == KIND_PUSH)
                    begin
                        prio_out_reg <= PRI_W'(prio_reg);
                        if (push_full)
                            dropped_reg <= 1'b1;
                        else
                        begin
                            granted_reg <= 1'b1;
                            count_reg[push_list] <= count_reg[push_list] + CNT_W'(1);
                        end
                    end
                    else if (set_hit)
                    begin
                        granted_reg  <= 1'b1;
                        prio_out_reg <= PRI_W'(set_prio);
                        count_reg[probe_list] <= count_reg[probe_list] - CNT_W'(1);
                        if (phase_reg != 2'd2)
                            head_reg[probe_list] <=
                                (32'(head_reg[probe_list]) + 1 >= 32'(LIST_DEPTH)) ? '0 :
                                head_reg[probe_list] + POS_W'(1);
                        source_reg <= (phase_reg == 2'd0) ? SRC_OWN :
                                      (phase_reg == 2'd1) ? SRC_GLOBAL : SRC_STOLEN;
                        victim_reg <= (phase_reg == 2'd2) ? VIC_W'(probe_reg) : '0;
                    end
                    else if (phase_reg == 2'd0)
                    begin
                        phase_reg <= 2'd1;
                        probe_reg <= GLOBAL_SET;
                    end
                    else if (phase_reg == 2'd1)
                    begin
                        phase_reg <= 2'd2;
                        if (local_reg)
                        begin
                            if (32'(req_set_reg) + 1 >= 32'(n_act))
                                probe_reg <= '0;
                            else
                                probe_reg <= req_set_reg + SET_W'(1);
                        end
                        else
                            probe_reg <= '0;
                    end
                    else
                    begin
                        probe_reg <= probe_inc;
                        steps_reg <= steps_reg + WCNT_W'(1);
                    end
                default:
                    ;
            endcase
        end
    end

    // request payload capture
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            kind_reg <= kind;
            tag_reg  <= task_tag;
        end
    end

    // hold the tag read from ram
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            ram_rdata_hold <= ram_rdata;
    end

    assign granted  = granted_reg;
    assign dropped  = dropped_reg;
    assign task_out = (kind_reg == KIND_TAKE && granted_reg) ? ram_rdata_hold : '0;
    assign prio_out = prio_out_reg;
    assign source   = source_reg;
    assign victim   = victim_reg;

`ifndef SYNTHESIS
    // a push never both grants and drops
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(granted && dropped))
        else $error("granted and dropped together");
    // result holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(task_out) && $stable(granted))
        else $error("result changed under stall");
    // no request taken while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken with result pending");
    // a failed take reports all zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted && !dropped |-> source == SRC_OWN && victim == '0)
        else $error("failed take has nonzero fields");
`endif

endmodule
